// ===== hdl/omb_pkg.sv =====
// Shared types, codes and constants of the obstacle mask brush stamp.
package omb_pkg;

   localparam int DEF_GRID_WIDTH  = 256;
   localparam int DEF_GRID_HEIGHT = 128;
   localparam int WORD_BITS       = 32;
   localparam int SEL_W           = 5;
   localparam int REG_BRUSH_RADIUS = 0;
   localparam logic [7:0] RADIUS_RESET = 8'd5;

   typedef enum logic [2:0] {
      OP_DISK_SET     = 3'd0,
      OP_DISK_CLEAR   = 3'd1,
      OP_CAPSULE_SET  = 3'd2,
      OP_BORDER_SET   = 3'd3,
      OP_BORDER_CLEAR = 3'd4,
      OP_CLEAR_ALL    = 3'd5,
      OP_READ_CELL    = 3'd6,
      OP_NONE         = 3'd7
   } op_type;

   typedef enum logic [3:0] {
      ST_BOOT,
      ST_BOOT_WAIT,
      ST_IDLE,
      ST_PREP1,
      ST_PREP2,
      ST_SWEEP,
      ST_DRAIN,
      ST_READ,
      ST_READ_WAIT,
      ST_WIPE_GO,
      ST_WIPE_WAIT,
      ST_RESULT
   } ctrl_state_type;

   // Sideband that travels with one cell through the coverage pipeline.
   typedef struct packed {
      logic             valid;
      logic             flush;
      logic             last;
      logic [SEL_W-1:0] bit_sel;
   } cell_tag_type;

   // Per-command brush geometry, constant during a sweep.
   typedef struct packed {
      op_type      op;
      logic [7:0]  ax;
      logic [6:0]  ay;
      logic [7:0]  bx;
      logic [6:0]  by;
      logic [8:0]  dx;
      logic [8:0]  dy;
      logic [16:0] len2;
      logic [15:0] r2;
      logic [32:0] r2len2;
   } brush_type;

   typedef struct packed {
      logic             valid;
      logic [SEL_W-1:0] bit_sel;
   } rd_req_type;

   typedef struct packed {
      logic done;
      logic rd_bit;
   } map_status_type;

   function automatic logic op_sets(op_type op);
      logic v;
      v = 1'b0;
      case (op) inside
         OP_DISK_SET, OP_CAPSULE_SET, OP_BORDER_SET: v = 1'b1;
         default: v = 1'b0;
      endcase
      return v;
   endfunction

endpackage

// ===== hdl/omb_if.sv =====
// Handshake channel interfaces for commands and results.
interface omb_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] operation;
   logic [7:0] start_x;
   logic [6:0] start_y;
   logic [7:0] end_x;
   logic [6:0] end_y;

   modport source (output valid, operation, start_x, start_y, end_x, end_y, input ready);
   modport sink (input valid, operation, start_x, start_y, end_x, end_y, output ready);
endinterface

interface omb_rsp_if;
   logic valid;
   logic ready;
   logic cell_value;

   modport source (output valid, cell_value, input ready);
   modport sink (input valid, cell_value, output ready);
endinterface

// ===== hdl/omb_cover.sv =====
// Pipelined per-cell coverage test for disk, capsule and border shapes.
module omb_cover #(
   parameter int GRID_WIDTH  = omb_pkg::DEF_GRID_WIDTH,
   parameter int GRID_HEIGHT = omb_pkg::DEF_GRID_HEIGHT,
   parameter int AW          = 10
) (
   input  logic                            clock,
   input  logic                            reset,
   input  omb_pkg::brush_type              brush,
   input  omb_pkg::cell_tag_type           in_tag,
   input  logic [$clog2(GRID_WIDTH)-1:0]   in_x,
   input  logic [$clog2(GRID_HEIGHT)-1:0]  in_y,
   input  logic [AW-1:0]                   in_word,
   output omb_pkg::cell_tag_type           out_tag,
   output logic                            out_hit,
   output logic [AW-1:0]                   out_word
);
   import omb_pkg::*;

   localparam int XW = $clog2(GRID_WIDTH);
   localparam int YW = $clog2(GRID_HEIGHT);
   localparam int MW = (XW > YW) ? XW : YW;
   localparam int DW = ((MW > 8) ? MW : 8) + 1;
   localparam int PW = DW + 9;
   localparam int SW = 2 * DW + 1;
   localparam int TW = DW + 10;
   localparam int QW = 2 * TW;

   cell_tag_type tag_s1_ff, tag_s2_ff, tag_s3_ff, tag_s4_ff, tag_s5_ff;
   logic [AW-1:0] word_s1_ff, word_s2_ff, word_s3_ff, word_s4_ff, word_s5_ff;
   logic border_s1_ff, border_s2_ff, border_s3_ff, border_s4_ff;

   logic signed [DW-1:0] px_ff, py_ff, qx_ff, qy_ff;
   logic signed [2*DW-1:0] sq_px_ff, sq_py_ff, sq_qx_ff, sq_qy_ff;
   logic signed [PW-1:0] pxdx_ff, pydy_ff, pxdy_ff, pydx_ff;
   logic signed [SW-1:0] dp_ff, dq_ff;
   logic signed [TW-1:0] dot_ff;
   logic [TW-1:0] acr_ff;
   logic [QW-1:0] cr2_ff;
   logic le0_ff, ge_ff, dp_lt_ff, dq_lt_ff;
   logic hit_ff;

   logic signed [8:0] dxs, dys;
   logic signed [TW-1:0] cr_c;
   logic border_in, cr_lt, hit_in;

   assign dxs = $signed(brush.dx);
   assign dys = $signed(brush.dy);

   assign border_in = (in_x == '0) || (in_x == XW'(GRID_WIDTH - 1)) ||
                      (in_y == '0) || (in_y == YW'(GRID_HEIGHT - 1));

   assign cr_c = TW'(pxdy_ff) - TW'(pydx_ff);
   assign cr_lt = cr2_ff < QW'(brush.r2len2);

   always_comb begin
      hit_in = 1'b0;
      case (brush.op) inside
         OP_DISK_SET, OP_DISK_CLEAR: hit_in = dp_lt_ff;
         OP_CAPSULE_SET: begin
            if (brush.len2 == '0) hit_in = 1'b0;
            else if (le0_ff) hit_in = dp_lt_ff;
            else if (ge_ff) hit_in = dq_lt_ff;
            else hit_in = cr_lt;
         end
         OP_BORDER_SET, OP_BORDER_CLEAR: hit_in = border_s4_ff;
         default: hit_in = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_s1_ff <= '0;
         tag_s2_ff <= '0;
         tag_s3_ff <= '0;
         tag_s4_ff <= '0;
         tag_s5_ff <= '0;
      end else begin
         tag_s1_ff <= in_tag;
         tag_s2_ff <= tag_s1_ff;
         tag_s3_ff <= tag_s2_ff;
         tag_s4_ff <= tag_s3_ff;
         tag_s5_ff <= tag_s4_ff;
      end
   end

   always_ff @(posedge clock) begin
      // Offsets from both segment ends.
      word_s1_ff   <= in_word;
      border_s1_ff <= border_in;
      px_ff <= DW'(in_x) - DW'(brush.ax);
      py_ff <= DW'(in_y) - DW'(brush.ay);
      qx_ff <= DW'(in_x) - DW'(brush.bx);
      qy_ff <= DW'(in_y) - DW'(brush.by);
      // Products.
      word_s2_ff   <= word_s1_ff;
      border_s2_ff <= border_s1_ff;
      sq_px_ff <= (2*DW)'(px_ff) * (2*DW)'(px_ff);
      sq_py_ff <= (2*DW)'(py_ff) * (2*DW)'(py_ff);
      sq_qx_ff <= (2*DW)'(qx_ff) * (2*DW)'(qx_ff);
      sq_qy_ff <= (2*DW)'(qy_ff) * (2*DW)'(qy_ff);
      pxdx_ff  <= PW'(px_ff) * PW'(dxs);
      pydy_ff  <= PW'(py_ff) * PW'(dys);
      pxdy_ff  <= PW'(px_ff) * PW'(dys);
      pydx_ff  <= PW'(py_ff) * PW'(dxs);
      // Sums, projection and cross product magnitude.
      word_s3_ff   <= word_s2_ff;
      border_s3_ff <= border_s2_ff;
      dp_ff  <= SW'(sq_px_ff) + SW'(sq_py_ff);
      dq_ff  <= SW'(sq_qx_ff) + SW'(sq_qy_ff);
      dot_ff <= TW'(pxdx_ff) + TW'(pydy_ff);
      acr_ff <= cr_c[TW-1] ? $unsigned(-cr_c) : $unsigned(cr_c);
      // Square of the cross product and the region decisions.
      word_s4_ff   <= word_s3_ff;
      border_s4_ff <= border_s3_ff;
      cr2_ff   <= QW'(acr_ff) * QW'(acr_ff);
      le0_ff   <= dot_ff <= 0;
      ge_ff    <= dot_ff >= $signed(TW'(brush.len2));
      dp_lt_ff <= $unsigned(dp_ff) < SW'(brush.r2);
      dq_lt_ff <= $unsigned(dq_ff) < SW'(brush.r2);
      // Final hit.
      word_s5_ff <= word_s4_ff;
      hit_ff     <= hit_in;
   end

   assign out_tag  = tag_s5_ff;
   assign out_hit  = hit_ff;
   assign out_word = word_s5_ff;

endmodule

// ===== hdl/omb_map.sv =====
// Obstacle map word memory with read-modify-write merge, wipe sweep and cell read.
module omb_map #(
   parameter int WORDS = 1024,
   parameter int AW    = 10
) (
   input  logic                   clock,
   input  logic                   reset,
   input  omb_pkg::op_type        op,
   input  omb_pkg::cell_tag_type  hit_tag,
   input  logic                   hit,
   input  logic [AW-1:0]          hit_word,
   input  logic                   wipe_start,
   input  omb_pkg::rd_req_type    rd_req,
   input  logic [AW-1:0]          rd_addr,
   output omb_pkg::map_status_type status
);
   import omb_pkg::*;

   logic [WORD_BITS-1:0] mem_ram [WORDS];
   logic [WORD_BITS-1:0] rd_data_ff;
   logic [SEL_W-1:0]     rd_sel_ff;

   logic [WORD_BITS-1:0] mask_ff, mask_in, mask_next;
   logic                 wb_pend_ff, wb_pend_in;
   logic                 wb_last_ff, wb_last_in;
   logic [AW-1:0]        wb_addr_ff;
   logic [WORD_BITS-1:0] wb_mask_ff;
   logic                 wipe_active_ff, wipe_active_in;
   logic [AW-1:0]        wipe_addr_ff, wipe_addr_in;

   logic                 flush;
   logic [AW-1:0]        raddr;
   logic                 we;
   logic [AW-1:0]        waddr;
   logic [WORD_BITS-1:0] wdata;
   logic                 wipe_end;

   assign flush     = hit_tag.valid && hit_tag.flush;
   assign mask_next = mask_ff | (WORD_BITS'(hit) << hit_tag.bit_sel);
   assign raddr     = flush ? hit_word : rd_addr;
   assign wipe_end  = wipe_active_ff && (wipe_addr_ff == AW'(WORDS - 1));

   always_comb begin
      mask_in        = mask_ff;
      wb_pend_in     = 1'b0;
      wb_last_in     = 1'b0;
      wipe_active_in = wipe_active_ff;
      wipe_addr_in   = wipe_addr_ff;
      if (hit_tag.valid) begin
         mask_in = flush ? '0 : mask_next;
      end
      if (flush) begin
         wb_pend_in = 1'b1;
         wb_last_in = hit_tag.last;
      end
      if (wipe_start) begin
         wipe_active_in = 1'b1;
         wipe_addr_in   = '0;
      end else if (wipe_active_ff) begin
         wipe_active_in = !wipe_end;
         wipe_addr_in   = wipe_addr_ff + 1'b1;
      end
      // The wipe and a pending merge never overlap.
      we    = wipe_active_ff || wb_pend_ff;
      waddr = wipe_active_ff ? wipe_addr_ff : wb_addr_ff;
      if (wipe_active_ff) wdata = '0;
      else if (op_sets(op)) wdata = rd_data_ff | wb_mask_ff;
      else wdata = rd_data_ff & ~wb_mask_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff        <= '0;
         wb_pend_ff     <= 1'b0;
         wb_last_ff     <= 1'b0;
         wipe_active_ff <= 1'b0;
         wipe_addr_ff   <= '0;
      end else begin
         mask_ff        <= mask_in;
         wb_pend_ff     <= wb_pend_in;
         wb_last_ff     <= wb_last_in;
         wipe_active_ff <= wipe_active_in;
         wipe_addr_ff   <= wipe_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (flush) begin
         wb_addr_ff <= hit_word;
         wb_mask_ff <= mask_next;
      end
      if (rd_req.valid) rd_sel_ff <= rd_req.bit_sel;
   end

   always_ff @(posedge clock) begin
      if (we) mem_ram[waddr] <= wdata;
      rd_data_ff <= mem_ram[raddr];
   end

   assign status.done   = (wb_pend_ff && wb_last_ff) || wipe_end;
   assign status.rd_bit = rd_data_ff[rd_sel_ff];

endmodule

// ===== hdl/omb_ctrl.sv =====
// Command sequencer: captures commands, prepares brush geometry, walks the cells.
module omb_ctrl #(
   parameter int GRID_WIDTH  = omb_pkg::DEF_GRID_WIDTH,
   parameter int GRID_HEIGHT = omb_pkg::DEF_GRID_HEIGHT,
   parameter int AW          = 10
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [7:0]                      radius,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [2:0]                      req_operation,
   input  logic [7:0]                      req_start_x,
   input  logic [6:0]                      req_start_y,
   input  logic [7:0]                      req_end_x,
   input  logic [6:0]                      req_end_y,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_cell_value,
   output omb_pkg::brush_type              brush,
   output omb_pkg::cell_tag_type           cell_tag,
   output logic [$clog2(GRID_WIDTH)-1:0]   cell_x,
   output logic [$clog2(GRID_HEIGHT)-1:0]  cell_y,
   output logic [AW-1:0]                   cell_word,
   output logic                            wipe_start,
   output omb_pkg::rd_req_type             rd_req,
   output logic [AW-1:0]                   rd_addr,
   input  omb_pkg::map_status_type         map_status
);
   import omb_pkg::*;

   localparam int XW    = $clog2(GRID_WIDTH);
   localparam int YW    = $clog2(GRID_HEIGHT);
   localparam int CW    = $clog2(GRID_WIDTH * GRID_HEIGHT);
   localparam int IXW   = ((CW > 20) ? CW : 20) + 1;

   ctrl_state_type state_ff, state_in;
   op_type         op_ff, op_in;
   logic [7:0]     ax_ff, ax_in, bx_ff, bx_in;
   logic [6:0]     ay_ff, ay_in, by_ff, by_in;
   logic           inrange_ff, inrange_in;
   logic [15:0]    r2_ff, r2_in;
   logic [16:0]    len2_ff, len2_in;
   logic [32:0]    r2len2_ff, r2len2_in;
   logic [IXW-1:0] idx_ff, idx_in;
   logic [XW-1:0]  x_ff, x_in;
   logic [YW-1:0]  y_ff, y_in;
   logic [AW-1:0]  word_ff, word_in;
   logic [SEL_W-1:0] sel_ff, sel_in;
   logic           res_ff, res_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           rsp_value_ff, rsp_value_in;

   logic [8:0]        dx_c, dy_c;
   logic signed [8:0] dxs, dys;
   logic              x_end, last_cell, flush;

   assign dx_c = {1'b0, bx_ff} - {1'b0, ax_ff};
   assign dy_c = {2'b0, by_ff} - {2'b0, ay_ff};
   assign dxs  = $signed(dx_c);
   assign dys  = $signed(dy_c);

   assign x_end     = x_ff == XW'(GRID_WIDTH - 1);
   assign last_cell = x_end && (y_ff == YW'(GRID_HEIGHT - 1));
   assign flush     = (sel_ff == SEL_W'(WORD_BITS - 1)) || last_cell;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      ax_in        = ax_ff;
      ay_in        = ay_ff;
      bx_in        = bx_ff;
      by_in        = by_ff;
      inrange_in   = inrange_ff;
      r2_in        = r2_ff;
      len2_in      = len2_ff;
      r2len2_in    = r2len2_ff;
      idx_in       = idx_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      word_in      = word_ff;
      sel_in       = sel_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_value_in = rsp_value_ff;
      req_ready    = 1'b0;
      wipe_start   = 1'b0;
      rd_req       = '0;
      cell_tag     = '0;

      unique case (state_ff)
         ST_BOOT: begin
            wipe_start = 1'b1;
            state_in   = ST_BOOT_WAIT;
         end
         ST_BOOT_WAIT: begin
            if (map_status.done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in      = op_type'(req_operation);
               ax_in      = req_start_x;
               ay_in      = req_start_y;
               bx_in      = req_end_x;
               by_in      = req_end_y;
               inrange_in = (32'(req_start_x) < 32'(GRID_WIDTH)) &&
                            (32'(req_start_y) < 32'(GRID_HEIGHT));
               res_in     = 1'b0;
               case (op_type'(req_operation))
                  OP_CLEAR_ALL: state_in = ST_WIPE_GO;
                  OP_NONE:      state_in = ST_RESULT;
                  default:      state_in = ST_PREP1;
               endcase
            end
         end
         ST_PREP1: begin
            r2_in    = 16'(radius) * 16'(radius);
            len2_in  = 17'(dxs * dxs) + 17'(dys * dys);
            idx_in   = IXW'(ay_ff) * IXW'(GRID_WIDTH) + IXW'(ax_ff);
            state_in = ST_PREP2;
         end
         ST_PREP2: begin
            r2len2_in = 33'(r2_ff) * 33'(len2_ff);
            x_in      = '0;
            y_in      = '0;
            word_in   = '0;
            sel_in    = '0;
            if (op_ff == OP_READ_CELL) begin
               state_in = inrange_ff ? ST_READ : ST_RESULT;
            end else begin
               state_in = ST_SWEEP;
            end
         end
         ST_SWEEP: begin
            cell_tag.valid   = 1'b1;
            cell_tag.flush   = flush;
            cell_tag.last    = last_cell;
            cell_tag.bit_sel = sel_ff;
            sel_in = sel_ff + 1'b1;
            if (flush) word_in = word_ff + 1'b1;
            if (x_end) begin
               x_in = '0;
               y_in = y_ff + 1'b1;
            end else begin
               x_in = x_ff + 1'b1;
            end
            if (last_cell) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (map_status.done) state_in = ST_RESULT;
         end
         ST_READ: begin
            rd_req.valid   = 1'b1;
            rd_req.bit_sel = idx_ff[SEL_W-1:0];
            state_in       = ST_READ_WAIT;
         end
         ST_READ_WAIT: begin
            res_in   = map_status.rd_bit;
            state_in = ST_RESULT;
         end
         ST_WIPE_GO: begin
            wipe_start = 1'b1;
            state_in   = ST_WIPE_WAIT;
         end
         ST_WIPE_WAIT: begin
            if (map_status.done) state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_BOOT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_BOOT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      ax_ff        <= ax_in;
      ay_ff        <= ay_in;
      bx_ff        <= bx_in;
      by_ff        <= by_in;
      inrange_ff   <= inrange_in;
      r2_ff        <= r2_in;
      len2_ff      <= len2_in;
      r2len2_ff    <= r2len2_in;
      idx_ff       <= idx_in;
      x_ff         <= x_in;
      y_ff         <= y_in;
      word_ff      <= word_in;
      sel_ff       <= sel_in;
      res_ff       <= res_in;
      rsp_value_ff <= rsp_value_in;
   end

   assign brush.op     = op_ff;
   assign brush.ax     = ax_ff;
   assign brush.ay     = ay_ff;
   assign brush.bx     = bx_ff;
   assign brush.by     = by_ff;
   assign brush.dx     = dx_c;
   assign brush.dy     = dy_c;
   assign brush.len2   = len2_ff;
   assign brush.r2     = r2_ff;
   assign brush.r2len2 = r2len2_ff;

   assign cell_x    = x_ff;
   assign cell_y    = y_ff;
   assign cell_word = word_ff;
   assign rd_addr   = AW'(idx_ff >> SEL_W);

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cell_value = rsp_value_ff;

endmodule

// ===== hdl/obstacle_mask_brush_stamp.sv =====
// Disk, capsule, border stamp, clear-all and read of a 1-bit obstacle map.
// Stamps and border commands test one cell per cycle.
// Clear all writes one 32-bit map word per cycle.
// One command is in flight at a time.
// Synchronous active-high reset; the block then wipes the map and takes its first
// command once the wipe is done.
module obstacle_mask_brush_stamp #(
   parameter int GRID_WIDTH  = omb_pkg::DEF_GRID_WIDTH,
   parameter int GRID_HEIGHT = omb_pkg::DEF_GRID_HEIGHT
) (
   input  logic        clock,
   input  logic        reset,
   omb_req_if.sink     req_if,
   omb_rsp_if.source   rsp_if,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [1:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import omb_pkg::*;

   // The map is held as 32-bit words, cell index y*GRID_WIDTH+x, bit index
   // in the low five bits.
   localparam int CELLS = GRID_WIDTH * GRID_HEIGHT;
   localparam int WORDS = (CELLS + WORD_BITS - 1) / WORD_BITS;
   localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int XW    = $clog2(GRID_WIDTH);
   localparam int YW    = $clog2(GRID_HEIGHT);

   // Brush radius register, the only configuration register. The port is
   // always ready, so a write transfer completes in its access cycle.
   logic [7:0] radius_ff, radius_in;
   logic       csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite &&
                      ((paddr >> 2) == 2'(REG_BRUSH_RADIUS));
   assign radius_in = csr_write ? pwdata[7:0] : radius_ff;
   assign prdata    = 32'(radius_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RADIUS_RESET;
      end else begin
         radius_ff <= radius_in;
      end
   end

   brush_type      brush;
   cell_tag_type   cell_tag, hit_tag;
   logic [XW-1:0]  cell_x;
   logic [YW-1:0]  cell_y;
   logic [AW-1:0]  cell_word, hit_word, rd_addr;
   logic           hit, wipe_start;
   rd_req_type     rd_req;
   map_status_type map_status;

   // The sequencer owns the command and result transfers. It walks every
   // cell in row-major order for stamp and border commands, starts the word
   // wipe for clear all and after reset, and issues the single-word read.
   omb_ctrl #(
      .GRID_WIDTH  (GRID_WIDTH),
      .GRID_HEIGHT (GRID_HEIGHT),
      .AW          (AW)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .radius         (radius_ff),
      .req_valid      (req_if.valid),
      .req_ready      (req_if.ready),
      .req_operation  (req_if.operation),
      .req_start_x    (req_if.start_x),
      .req_start_y    (req_if.start_y),
      .req_end_x      (req_if.end_x),
      .req_end_y      (req_if.end_y),
      .rsp_valid      (rsp_if.valid),
      .rsp_ready      (rsp_if.ready),
      .rsp_cell_value (rsp_if.cell_value),
      .brush          (brush),
      .cell_tag       (cell_tag),
      .cell_x         (cell_x),
      .cell_y         (cell_y),
      .cell_word      (cell_word),
      .wipe_start     (wipe_start),
      .rd_req         (rd_req),
      .rd_addr        (rd_addr),
      .map_status     (map_status)
   );

   // Five-stage exact integer coverage test, one cell per cycle.
   omb_cover #(
      .GRID_WIDTH  (GRID_WIDTH),
      .GRID_HEIGHT (GRID_HEIGHT),
      .AW          (AW)
   ) u_cover (
      .clock    (clock),
      .reset    (reset),
      .brush    (brush),
      .in_tag   (cell_tag),
      .in_x     (cell_x),
      .in_y     (cell_y),
      .in_word  (cell_word),
      .out_tag  (hit_tag),
      .out_hit  (hit),
      .out_word (hit_word)
   );

   // Hits of one word are gathered into a mask; when the word is complete
   // it is read and written back merged on the next cycle. Consecutive
   // words differ, so a write never meets a read of the same word.
   omb_map #(
      .WORDS (WORDS),
      .AW    (AW)
   ) u_map (
      .clock      (clock),
      .reset      (reset),
      .op         (brush.op),
      .hit_tag    (hit_tag),
      .hit        (hit),
      .hit_word   (hit_word),
      .wipe_start (wipe_start),
      .rd_req     (rd_req),
      .rd_addr    (rd_addr),
      .status     (map_status)
   );

endmodule

// ===== hdl/omb_checker.sv =====
// Port-level checks of the obstacle mask brush stamp, bound to the top level.
module omb_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_cell_value
);

   // A stalled result stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result withdrawn while stalled");

   // A stalled result keeps its value.
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_cell_value))
      else $error("result value changed while stalled");

   // The map wipe after reset keeps the command side closed.
   a_boot_closed: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !req_ready)
      else $error("command taken during the reset wipe");

   // One command at a time: a transfer closes the command side.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second command taken while one is in flight");

endmodule

bind obstacle_mask_brush_stamp omb_checker u_omb_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_if.valid),
   .req_ready      (req_if.ready),
   .rsp_valid      (rsp_if.valid),
   .rsp_ready      (rsp_if.ready),
   .rsp_cell_value (rsp_if.cell_value)
);

// ===== bench/tb_obstacle_mask_brush_stamp.sv =====
// Self-checking testbench for the obstacle mask brush stamp block.
`timescale 1ns / 100ps

// Tracks the obstacle map as the block should hold it and keeps the read answers still owed.
class cell_map_tracker;
   localparam int MAP_W = omb_pkg::DEF_GRID_WIDTH;
   localparam int MAP_H = omb_pkg::DEF_GRID_HEIGHT;

   bit         cells[MAP_W*MAP_H];
   bit [7:0]   radius;
   bit         owed_cells[$];
   int         errors;

   function new();
      radius = omb_pkg::RADIUS_RESET;
      errors = 0;
   endfunction

   function void stamp_disk(longint cx, longint cy, bit v);
      longint r2, dx, dy;
      r2 = longint'(radius) * longint'(radius);
      for (int y = 0; y < MAP_H; y++)
         for (int x = 0; x < MAP_W; x++) begin
            dx = x - cx;
            dy = y - cy;
            if (dx*dx + dy*dy < r2) cells[y*MAP_W + x] = v;
         end
   endfunction

   function void stamp_capsule(longint ax, longint ay, longint bx, longint by);
      longint r2, dx, dy, len2, px, py, qx, qy, dot, cr;
      bit hit;
      r2 = longint'(radius) * longint'(radius);
      dx = bx - ax;
      dy = by - ay;
      len2 = dx*dx + dy*dy;
      // A segment of zero length marks nothing at all.
      if (len2 == 0) return;
      for (int y = 0; y < MAP_H; y++)
         for (int x = 0; x < MAP_W; x++) begin
            px = x - ax;
            py = y - ay;
            dot = px*dx + py*dy;
            if (dot <= 0) begin
               hit = (px*px + py*py < r2);
            end else if (dot >= len2) begin
               qx = x - bx;
               qy = y - by;
               hit = (qx*qx + qy*qy < r2);
            end else begin
               cr = px*dy - py*dx;
               hit = (cr*cr < r2*len2);
            end
            if (hit) cells[y*MAP_W + x] = 1'b1;
         end
   endfunction

   function void stamp_border(bit v);
      for (int x = 0; x < MAP_W; x++) begin
         cells[x] = v;
         cells[(MAP_H-1)*MAP_W + x] = v;
      end
      for (int y = 0; y < MAP_H; y++) begin
         cells[y*MAP_W] = v;
         cells[y*MAP_W + MAP_W - 1] = v;
      end
   endfunction

   // Applies one accepted command and queues the answer it owes.
   function void note_command(omb_pkg::op_type op, bit [7:0] sx, bit [6:0] sy,
                              bit [7:0] ex, bit [6:0] ey);
      bit answer;
      answer = 1'b0;
      case (op)
         omb_pkg::OP_DISK_SET:     stamp_disk(sx, sy, 1'b1);
         omb_pkg::OP_DISK_CLEAR:   stamp_disk(sx, sy, 1'b0);
         omb_pkg::OP_CAPSULE_SET:  stamp_capsule(sx, sy, ex, ey);
         omb_pkg::OP_BORDER_SET:   stamp_border(1'b1);
         omb_pkg::OP_BORDER_CLEAR: stamp_border(1'b0);
         omb_pkg::OP_CLEAR_ALL:    foreach (cells[i]) cells[i] = 1'b0;
         omb_pkg::OP_READ_CELL:    answer = cells[int'(sy)*MAP_W + int'(sx)];
         default:                  answer = 1'b0;
      endcase
      owed_cells.push_back(answer);
   endfunction

   function void check_cell_value(bit actual);
      bit want;
      if (owed_cells.size() == 0) begin
         $error("cell_value: no result expected, actual %0d", actual);
         errors++;
         return;
      end
      want = owed_cells.pop_front();
      if (want !== actual) begin
         $error("cell_value: expected %0d, actual %0d", want, actual);
         errors++;
      end
   endfunction
endclass

module tb_obstacle_mask_brush_stamp;
   import omb_pkg::*;

   // A full sweep is 32768 cells; allow for far more than the slowest correct
   // run, including the wipe after reset and every stall.
   localparam longint CYCLE_LIMIT = 64'd8_000_000;
   localparam int     HOLD_CYCLES = 400;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [1:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   omb_req_if req_bus();
   omb_rsp_if rsp_bus();

   cell_map_tracker map_model;
   longint          cycle_count = 0;
   int              snd_idle_pct = 0;
   int              rcv_stall_pct = 0;
   bit              hold_go = 1'b0;
   // The center of the latest stamp, so that random reads land near its edge.
   bit [7:0]        focus_x = 8'd128;
   bit [6:0]        focus_y = 7'd64;

   obstacle_mask_brush_stamp u_top (
      .clock   (clock),
      .reset   (reset),
      .req_if  (req_bus),
      .rsp_if  (rsp_bus),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready)
   );

   always #1 clock = ~clock;

   initial begin
      req_bus.valid = 1'b0;
      req_bus.operation = OP_NONE;
      req_bus.start_x = '0;
      req_bus.start_y = '0;
      req_bus.end_x = '0;
      req_bus.end_y = '0;
      rsp_bus.ready = 1'b0;
   end

   // The run ends here if the block stops making progress.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // The receiver stalls at random, and holds off for a long stretch on request
   // while the sender keeps offering commands.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_go) begin
            hold_go = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_bus.ready <= ($urandom_range(99) >= rcv_stall_pct);
      end
   end

   // Every result transfer is checked against the oldest owed answer.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         map_model.check_cell_value(rsp_bus.cell_value);
   end

   // Offers one command, idling first at random, and returns once it is accepted.
   // Valid stays high afterwards so back-to-back transfers are possible.
   task automatic send_command(op_type op, bit [7:0] sx, bit [6:0] sy,
                               bit [7:0] ex, bit [6:0] ey);
      while ($urandom_range(99) < snd_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.operation <= op;
      req_bus.start_x <= sx;
      req_bus.start_y <= sy;
      req_bus.end_x <= ex;
      req_bus.end_y <= ey;
      do @(posedge clock); while (!req_bus.ready);
      map_model.note_command(op, sx, sy, ex, ey);
   endtask

   // Waits until every owed answer has come back and the block has settled.
   task automatic wait_until_idle();
      req_bus.valid <= 1'b0;
      while (map_model.owed_cells.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   // Write of the brush radius register: a setup phase, then an access phase.
   task automatic write_radius(bit [7:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= 2'(REG_BRUSH_RADIUS * 4);
      csr_pwdata <= {24'd0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      map_model.radius = value;
   endtask

   // A read near the latest stamp, or anywhere in the grid.
   task automatic read_random();
      bit [7:0] rx;
      bit [6:0] ry;
      if ($urandom_range(1)) begin
         rx = 8'(int'(focus_x) + $urandom_range(40) - 20);
         ry = 7'(int'(focus_y) + $urandom_range(40) - 20);
      end else begin
         rx = 8'($urandom);
         ry = 7'($urandom);
      end
      send_command(OP_READ_CELL, rx, ry, 8'($urandom), 7'($urandom));
   endtask

   // Mostly reads, since every stamp costs a whole sweep of the grid.
   task automatic random_commands(int count);
      int       pick;
      bit [7:0] sx, ex;
      bit [6:0] sy, ey;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(199);
         sx = 8'($urandom);
         sy = 7'($urandom);
         if (pick < 3) begin
            focus_x = sx;
            focus_y = sy;
            send_command(OP_DISK_SET, sx, sy, 8'($urandom), 7'($urandom));
         end else if (pick < 5) begin
            focus_x = sx;
            focus_y = sy;
            send_command(OP_DISK_CLEAR, sx, sy, 8'($urandom), 7'($urandom));
         end else if (pick < 8) begin
            focus_x = sx;
            focus_y = sy;
            if ($urandom_range(3) == 0) begin
               ex = sx;
               ey = sy;
            end else begin
               ex = 8'($urandom);
               ey = 7'($urandom);
            end
            send_command(OP_CAPSULE_SET, sx, sy, ex, ey);
         end else if (pick == 8) begin
            send_command(OP_BORDER_SET, sx, sy, 8'($urandom), 7'($urandom));
         end else if (pick == 9) begin
            send_command(OP_BORDER_CLEAR, sx, sy, 8'($urandom), 7'($urandom));
         end else if (pick < 12) begin
            send_command(OP_CLEAR_ALL, sx, sy, 8'($urandom), 7'($urandom));
         end else if (pick < 16) begin
            send_command(OP_NONE, sx, sy, 8'($urandom), 7'($urandom));
         end else begin
            read_random();
         end
      end
   endtask

   initial begin
      map_model = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed commands at the default radius of five.
      send_command(OP_DISK_SET, 8'd128, 7'd64, 8'd0, 7'd0);
      send_command(OP_READ_CELL, 8'd128, 7'd64, 8'd0, 7'd0);
      send_command(OP_READ_CELL, 8'd132, 7'd64, 8'd0, 7'd0);
      // Exactly on the radius, so the cell is not covered.
      send_command(OP_READ_CELL, 8'd133, 7'd64, 8'd0, 7'd0);
      send_command(OP_DISK_SET, 8'd255, 7'd127, 8'hFF, 7'h7F);
      send_command(OP_READ_CELL, 8'd255, 7'd127, 8'hFF, 7'h7F);
      send_command(OP_CAPSULE_SET, 8'd10, 7'd10, 8'd60, 7'd40);
      send_command(OP_READ_CELL, 8'd35, 7'd25, 8'd0, 7'd0);
      send_command(OP_READ_CELL, 8'd6, 7'd8, 8'd0, 7'd0);
      // A capsule whose ends coincide leaves the map alone.
      send_command(OP_CAPSULE_SET, 8'd200, 7'd100, 8'd200, 7'd100);
      send_command(OP_READ_CELL, 8'd200, 7'd100, 8'd0, 7'd0);
      send_command(OP_BORDER_SET, 8'd0, 7'd0, 8'd0, 7'd0);
      send_command(OP_READ_CELL, 8'd0, 7'd77, 8'd0, 7'd0);
      send_command(OP_DISK_CLEAR, 8'd128, 7'd64, 8'd0, 7'd0);
      send_command(OP_READ_CELL, 8'd128, 7'd64, 8'd0, 7'd0);
      // The unused operation changes nothing and answers zero.
      send_command(OP_NONE, 8'hFF, 7'h7F, 8'hFF, 7'h7F);
      send_command(OP_BORDER_CLEAR, 8'd0, 7'd0, 8'd0, 7'd0);
      send_command(OP_READ_CELL, 8'd255, 7'd0, 8'd0, 7'd0);
      send_command(OP_CLEAR_ALL, 8'd0, 7'd0, 8'd0, 7'd0);
      send_command(OP_READ_CELL, 8'd255, 7'd127, 8'd0, 7'd0);
      wait_until_idle();

      // With a zero radius no stamp covers anything.
      write_radius(8'd0);
      send_command(OP_DISK_SET, 8'd50, 7'd50, 8'd0, 7'd0);
      send_command(OP_READ_CELL, 8'd50, 7'd50, 8'd0, 7'd0);
      wait_until_idle();

      // The largest radius, centred on a corner, still leaves the far corner uncovered.
      write_radius(8'd255);
      send_command(OP_DISK_SET, 8'd0, 7'd0, 8'd0, 7'd0);
      send_command(OP_READ_CELL, 8'd255, 7'd127, 8'd0, 7'd0);
      wait_until_idle();

      // Random phases: sender idles lightly while the receiver stalls often.
      snd_idle_pct = 15;
      rcv_stall_pct = 57;
      write_radius(8'd1);
      random_commands(190);
      wait_until_idle();

      snd_idle_pct = 57;
      rcv_stall_pct = 15;
      write_radius(8'($urandom_range(2, 30)));
      random_commands(190);
      wait_until_idle();

      // No idling; the receiver holds off long enough to back up the input.
      snd_idle_pct = 0;
      rcv_stall_pct = 0;
      write_radius(8'($urandom_range(3, 60)));
      hold_go = 1'b1;
      random_commands(180);
      wait_until_idle();
      repeat (20) @(posedge clock);

      if (map_model.errors == 0 && map_model.owed_cells.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule
